// ===== sv/wavhdr_pkg.sv =====
// Shared types, constants and helpers for the WAV header duration parser.
// Used by the capture stage, the bit-serial divider and the top level.
`default_nettype none

package wavhdr_pkg;

	// header offsets (6-bit byte counter)
	localparam logic [5:0] OFF_MAGIC_GAP_LO = 6'd4;
	localparam logic [5:0] OFF_MAGIC_GAP_HI = 6'd7;
	localparam logic [5:0] OFF_MAGIC_END    = 6'd15;
	localparam logic [5:0] OFF_CH_LO        = 6'd22;
	localparam logic [5:0] OFF_CH_HI        = 6'd23;
	localparam logic [5:0] OFF_RATE_LO      = 6'd24;
	localparam logic [5:0] OFF_RATE_HI      = 6'd27;
	localparam logic [5:0] OFF_BITS_LO      = 6'd34;
	localparam logic [5:0] OFF_BITS_HI      = 6'd35;
	localparam logic [5:0] OFF_LEN_LO       = 6'd40;
	localparam logic [5:0] OFF_LAST         = 6'd43;

	localparam logic [15:0] BITS_8  = 16'd8;
	localparam logic [15:0] BITS_16 = 16'd16;

	localparam int unsigned DIV_W = 32;
	localparam int unsigned CNT_W = $clog2(DIV_W);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_BAD_BITS  = 3'd2,
		ST_ZERO_CH   = 3'd3,
		ST_ZERO_RATE = 3'd4,
		ST_SHORT     = 3'd5
	} status_t;

	// per-byte events from the capture stage
	typedef struct packed {
		logic emit;      // this byte ends a header (short or complete)
		logic last;      // this byte is offset 43
		logic magic_ok;  // all magic bytes so far matched
	} evt_t;

	// expected bytes: "RIFF" at 0-3, "WAVE" at 8-11, "fmt " at 12-15
	function automatic logic [7:0] magic_byte(input logic [3:0] off);
		logic [7:0] b;
		unique case (off)
			4'd0:    b = 8'h52;
			4'd1:    b = 8'h49;
			4'd2:    b = 8'h46;
			4'd3:    b = 8'h46;
			4'd8:    b = 8'h57;
			4'd9:    b = 8'h41;
			4'd10:   b = 8'h56;
			4'd11:   b = 8'h45;
			4'd12:   b = 8'h66;
			4'd13:   b = 8'h6D;
			4'd14:   b = 8'h74;
			4'd15:   b = 8'h20;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== sv/wavhdr_capture.sv =====
// Byte-serial header capture: offset counter, magic check and little-endian
// field shift registers. Depends on wavhdr_pkg.
`default_nettype none

module wavhdr_capture
	import wavhdr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_file,
	input  wire logic        end_of_file,
	output evt_t             evt,
	output logic [15:0]      ch_val,
	output logic [31:0]      rate_val,
	output logic [15:0]      bits_val,
	output logic [31:0]      len_val
);

	logic [5:0]  cnt_q;
	logic        done_q;
	logic        magic_q;
	logic [15:0] ch_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic [31:0] len_q;

	logic       active;
	logic [5:0] off;
	logic       magic_off;
	logic       mismatch;
	logic       take;

	assign active    = start_of_file | ~done_q;
	assign off       = start_of_file ? 6'd0 : cnt_q;
	assign magic_off = (off <= OFF_MAGIC_END) &&
	                   !((off >= OFF_MAGIC_GAP_LO) && (off <= OFF_MAGIC_GAP_HI));
	assign mismatch  = magic_off && (data_byte != magic_byte(off[3:0]));
	assign take      = fire & active;

	assign evt.emit     = active & (end_of_file | (off == OFF_LAST));
	assign evt.last     = active & (off == OFF_LAST);
	assign evt.magic_ok = magic_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			done_q  <= 1'b1;
			magic_q <= 1'b1;
		end else if (take) begin
			cnt_q   <= off + 6'd1;
			done_q  <= evt.emit;
			magic_q <= (start_of_file | magic_q) & ~mismatch;
		end
	end

	// every field byte is overwritten by offset 43, so no clear needed
	always_ff @(posedge clk) begin
		if (take) begin
			if (off >= OFF_CH_LO && off <= OFF_CH_HI)
				ch_q <= {data_byte, ch_q[15:8]};
			if (off >= OFF_RATE_LO && off <= OFF_RATE_HI)
				rate_q <= {data_byte, rate_q[31:8]};
			if (off >= OFF_BITS_LO && off <= OFF_BITS_HI)
				bits_q <= {data_byte, bits_q[15:8]};
			if (off >= OFF_LEN_LO && off <= OFF_LAST)
				len_q <= {data_byte, len_q[31:8]};
		end
	end

	assign ch_val   = ch_q;
	assign rate_val = rate_q;
	assign bits_val = bits_q;
	assign len_val  = len_q;

endmodule

`default_nettype wire

// ===== sv/wavhdr_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on wavhdr_pkg. Denominator must be nonzero.
`default_nettype none

module wavhdr_divider
	import wavhdr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] num,
	input  wire logic [DIV_W-1:0] den,
	output logic                  done,
	output logic [DIV_W-1:0]      quo
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;   // numerator bits shift out, quotient bits shift in
	logic [DIV_W-1:0] den_q;

	logic [DIV_W:0] shifted;
	logic [DIV_W:0] diff;
	logic           q_bit;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign q_bit   = ~diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= q_bit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], q_bit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ===== sv/wav_header_duration_parser.sv =====
// WAV header duration parser, top level: capture stage, shared bit-serial
// divider and the duration sequencer. Depends on wavhdr_pkg.
//
// Bytes of a file are taken one per cycle, while in_stall is low, from the
// start-of-file mark on. A file that ends early or fails a header check
// gives its result in the output register in the cycle after the byte that
// settles it is taken. A header that passes the checks keeps the sequencer
// busy, with in_stall high, for two 32-bit divides on the one-bit-per-cycle
// divider (each after its own load state), a two-step multiply by 1000 and
// the hand-off to the output register. One result waits in the output
// register while header bytes keep coming in; a byte that would give a
// second result is stalled until the first is taken.
`default_nettype none

module wav_header_duration_parser
	import wavhdr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_file,
	input  wire logic        end_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [31:0]      duration_ms,
	output logic [31:0]      rate_hz,
	output logic [15:0]      channels,
	output logic             is_mono
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_LD1   = 8'b0000_0010,
		S_DIV1  = 8'b0000_0100,
		S_MUL_A = 8'b0000_1000,
		S_MUL_B = 8'b0001_0000,
		S_LD2   = 8'b0010_0000,
		S_DIV2  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} seq_state_t;

	seq_state_t state_q;
	logic       small_q;   // samples < rate: multiply first, then divide
	logic [31:0] acc_q;
	logic [31:0] mul_x_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] dur_q;
	logic [31:0] rate_q;
	logic [15:0] ch_q;
	logic        mono_q;

	evt_t        evt;
	logic [15:0] cap_ch;
	logic [31:0] cap_rate;
	logic [15:0] cap_bits;
	logic [31:0] cap_len;

	logic             in_fire;
	logic             out_free;
	status_t          imm_status;
	logic             imm_load;
	logic             seq_start;
	logic             seq_load;
	logic [16:0]      frame;
	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic [DIV_W-1:0] div_den;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = (state_q != S_IDLE) | (out_valid_q & out_stall & evt.emit);
	assign in_fire  = in_valid & ~in_stall;

	wavhdr_capture u_capture (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (in_fire),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.end_of_file   (end_of_file),
		.evt           (evt),
		.ch_val        (cap_ch),
		.rate_val      (cap_rate),
		.bits_val      (cap_bits),
		.len_val       (cap_len)
	);

	// checks in order; only the last header byte can pass them all
	always_comb begin
		priority if (!evt.last)                                  imm_status = ST_SHORT;
		else if (!evt.magic_ok)                                  imm_status = ST_BAD_MAGIC;
		else if (cap_bits != BITS_8 && cap_bits != BITS_16)      imm_status = ST_BAD_BITS;
		else if (cap_ch == 16'd0)                                imm_status = ST_ZERO_CH;
		else if (cap_rate == 32'd0)                              imm_status = ST_ZERO_RATE;
		else                                                     imm_status = ST_OK;
	end

	assign seq_start = in_fire & evt.emit & (imm_status == ST_OK);
	assign imm_load  = in_fire & evt.emit & (imm_status != ST_OK);
	assign seq_load  = (state_q == S_DONE) & out_free;

	// bytes per sample is 1 or 2 here
	assign frame     = (cap_bits == BITS_16) ? {cap_ch, 1'b0} : {1'b0, cap_ch};
	assign div_start = (state_q == S_LD1) | (state_q == S_LD2);
	assign div_num   = (state_q == S_LD1) ? cap_len : acc_q;
	assign div_den   = (state_q == S_LD1) ? {{(DIV_W-17){1'b0}}, frame} : cap_rate;

	wavhdr_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (seq_start) state_q <= S_LD1;
				S_LD1:   state_q <= S_DIV1;
				S_DIV1:  if (div_done) state_q <= (div_quo < cap_rate) ? S_MUL_A : S_LD2;
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= small_q ? S_LD2 : S_DONE;
				S_LD2:   state_q <= S_DIV2;
				S_DIV2:  if (div_done) state_q <= small_q ? S_DONE : S_MUL_A;
				S_DONE:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// x*1000 mod 2^32 as (x<<10) - (x<<4) - (x<<3), over states S_MUL_A and S_MUL_B
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_DIV1: begin
				if (div_done) begin
					acc_q   <= div_quo;
					small_q <= div_quo < cap_rate;
				end
			end
			S_DIV2: begin
				if (div_done)
					acc_q <= div_quo;
			end
			S_MUL_A: begin
				mul_x_q <= acc_q;
				acc_q   <= (acc_q << 10) - (acc_q << 4);
			end
			S_MUL_B: acc_q <= acc_q - (mul_x_q << 3);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (imm_load | seq_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (imm_load) begin
			status_q <= imm_status;
			dur_q    <= '0;
			rate_q   <= '0;
			ch_q     <= '0;
			mono_q   <= 1'b0;
		end else if (seq_load) begin
			status_q <= ST_OK;
			dur_q    <= acc_q;
			rate_q   <= cap_rate;
			ch_q     <= cap_ch;
			mono_q   <= cap_ch == 16'd1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign duration_ms = dur_q;
	assign rate_hz     = rate_q;
	assign channels    = ch_q;
	assign is_mono     = mono_q;

	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (duration_ms == 32'd0 && rate_hz == 32'd0 &&
		                                    channels == 16'd0 && !is_mono))
		else $error("error transaction carries nonzero fields");

	a_mono_one_ch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_mono) |-> (channels == 16'd1))
		else $error("is_mono set without exactly one channel");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider finished outside a divide state");

	a_ok_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid) && status == ST_OK) |-> $past(state_q == S_DONE))
		else $error("ok transaction not produced by the sequencer");

endmodule

`default_nettype wire
